>>> src/xdr_pkg.sv
// Shared constants, widths and the generator step function for the dice roller.
package xdr_pkg;

  // Request bounds and field widths
  localparam int unsigned MaxDice = 100;
  localparam int unsigned DiceW   = 7;
  localparam int unsigned SideW   = 20;
  localparam int unsigned MultW   = 16;
  localparam int unsigned ModW    = 21;
  localparam int unsigned TotalW  = 44;

  // Internal widths
  localparam int unsigned CountW  = $clog2(MaxDice + 1);
  localparam int unsigned SumW    = $clog2(longint'(MaxDice) * (longint'(1) << SideW) + 1);
  localparam int unsigned WideW   = 65;

  // Remainder unit: bits retired per cycle, iteration count per 64-bit dividend and counter width
  localparam int unsigned ModBits  = 4;
  localparam int unsigned ModIters = 64 / ModBits;
  localparam int unsigned ModCntW  = $clog2(ModIters);

  // Generator constants
  localparam logic [63:0] GoldenSeed  = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] ScrambleMul = 64'h2545_F491_4F6C_DD1D;

  // Signed limits of the total field
  localparam longint TotalMaxL = (longint'(1) <<< (TotalW - 1)) - 1;
  localparam longint TotalMinL = -TotalMaxL - 1;

  // One xorshift64* state update (shifts 12, 25, 27)
  function automatic logic [63:0] xorshift_step(input logic [63:0] s);
    logic [63:0] t;
    t = s ^ (s >> 12);
    t = t ^ (t << 25);
    t = t ^ (t >> 27);
    return t;
  endfunction

endpackage

>>> src/xorshift_dice_roller_unit.sv
// Top level of the dice roller: sequencer, generator state and output register.
//
// A request transaction on the input channel (in_valid_i / in_stall_o) carries
// dice_count_i, sides_i, multiplier_i and modifier_i. One result transaction on
// the output channel (out_valid_o / out_stall_i) carries total_o, the dice sum
// times the multiplier plus the signed modifier. Counts above MaxDice roll
// MaxDice dice; zero sides or a zero count give the modifier alone.
// Requests are taken one at a time: in_stall_o is high from acceptance until
// the result is loaded into the output register. Each die takes one generator
// step, three partial products on the shared 32x32 multiplier, and a pass
// through the remainder unit, which retires 4 dividend bits a cycle.
// A finished result waits in the output register while out_stall_i is high; a
// new request can be accepted meanwhile, and its result is held back until the
// register frees. cfg_we_i loads the generator state from cfg_wdata_i (a zero
// seed loads the golden-ratio constant); write only while the block is idle.
// Reset loads the golden-ratio seed and empties the output register.
module xorshift_dice_roller_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [63:0]                       cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [xdr_pkg::DiceW-1:0]         dice_count_i,
  input  logic [xdr_pkg::SideW-1:0]         sides_i,
  input  logic [xdr_pkg::MultW-1:0]         multiplier_i,
  input  logic signed [xdr_pkg::ModW-1:0]   modifier_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [xdr_pkg::TotalW-1:0] total_o
);
  import xdr_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StRoll,
    StMul1,
    StMul2,
    StMul3,
    StMod,
    StScale,
    StFinish
  } state_e;

  state_e                   state_q, state_d;
  logic [63:0]              gen_q, gen_d;
  logic [63:0]              x_q, x_d;
  logic [63:0]              acc_q, acc_d;
  logic [CountW-1:0]        cnt_q, cnt_d;
  logic [SideW-1:0]         sides_q, sides_d;
  logic [MultW-1:0]         mult_q, mult_d;
  logic signed [ModW-1:0]   mod_q, mod_d;
  logic [SumW-1:0]          sum_q, sum_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [TotalW-1:0] total_q, total_d;

  logic [31:0]              mul_a, mul_b;
  logic [63:0]              mul_p;
  logic                     mod_start;
  logic [63:0]              mod_dividend;
  logic                     mod_done;
  logic [SideW-1:0]         mod_rem;
  logic [63:0]              step_s;
  logic signed [WideW-1:0]  wide_total;
  logic                     out_free;
  logic [CountW-1:0]        cnt_in;

  xdr_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  xdr_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dividend),
    .divisor_i  (sides_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign step_s       = xorshift_step(gen_q);
  assign mod_start    = (state_q == StMul3);
  assign mod_dividend = {acc_q[63:32] + mul_p[31:0], acc_q[31:0]};
  assign wide_total   = $signed({1'b0, mul_p}) + WideW'(mod_q);
  assign out_free     = !out_valid_q || !out_stall_i;
  assign cnt_in       = (32'(dice_count_i) > MaxDice) ? CountW'(MaxDice)
                                                      : CountW'(dice_count_i);

  // Feed the shared multiplier per sequencer step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StRoll: begin
        mul_a = step_s[31:0];
        mul_b = ScrambleMul[31:0];
      end
      StMul1: begin
        mul_a = x_q[31:0];
        mul_b = ScrambleMul[63:32];
      end
      StMul2: begin
        mul_a = x_q[63:32];
        mul_b = ScrambleMul[31:0];
      end
      StScale, StFinish: begin
        mul_a = 32'(sum_q);
        mul_b = 32'(mult_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer next-state and datapath updates
  always_comb begin
    state_d     = state_q;
    gen_d       = gen_q;
    x_d         = x_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    sides_d     = sides_q;
    mult_d      = mult_q;
    mod_d       = mod_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    total_d     = total_q;

    // Drop the result once the receiver takes it
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cnt_d   = cnt_in;
          sides_d = sides_i;
          mult_d  = multiplier_i;
          mod_d   = modifier_i;
          sum_d   = '0;
          if (cnt_in == '0 || sides_i == '0) begin
            state_d = StScale;
          end else begin
            state_d = StRoll;
          end
        end
      end
      StRoll: begin
        gen_d   = step_s;
        x_d     = step_s;
        state_d = StMul1;
      end
      StMul1: begin
        acc_d   = mul_p;
        state_d = StMul2;
      end
      StMul2: begin
        acc_d[63:32] = acc_q[63:32] + mul_p[31:0];
        state_d      = StMul3;
      end
      StMul3: begin
        state_d = StMod;
      end
      StMod: begin
        if (mod_done) begin
          sum_d = sum_q + SumW'(mod_rem) + SumW'(1);
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == CountW'(1)) begin
            state_d = StScale;
          end else begin
            state_d = StRoll;
          end
        end
      end
      StScale: begin
        state_d = StFinish;
      end
      StFinish: begin
        if (out_free) begin
          if (wide_total > $signed(WideW'(TotalMaxL))) begin
            total_d = TotalW'(TotalMaxL);
          end else if (wide_total < $signed(WideW'(TotalMinL))) begin
            total_d = TotalW'(TotalMinL);
          end else begin
            total_d = wide_total[TotalW-1:0];
          end
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // Load the seed; zero maps to the golden-ratio constant
    if (cfg_we_i) begin
      gen_d = (cfg_wdata_i == '0) ? GoldenSeed : cfg_wdata_i;
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      gen_q       <= GoldenSeed;
      out_valid_q <= 1'b0;
      x_q         <= '0;
      acc_q       <= '0;
      cnt_q       <= '0;
      sides_q     <= '0;
      mult_q      <= '0;
      mod_q       <= '0;
      sum_q       <= '0;
      total_q     <= '0;
    end else begin
      state_q     <= state_d;
      gen_q       <= gen_d;
      out_valid_q <= out_valid_d;
      x_q         <= x_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      sides_q     <= sides_d;
      mult_q      <= mult_d;
      mod_q       <= mod_d;
      sum_q       <= sum_d;
      total_q     <= total_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign total_o     = total_q;

endmodule

>>> src/xdr_mul.sv
// Shared 32x32 multiplier with a registered 64-bit product.
module xdr_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);
  import xdr_pkg::*;

  logic [63:0] p_q;

  // Register the product every cycle
  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

>>> src/xdr_mod.sv
// Iterative remainder unit: 64-bit dividend modulo a 20-bit divisor, ModBits bits per cycle.
module xdr_mod (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [63:0]                 dividend_i,
  input  logic [xdr_pkg::SideW-1:0]   divisor_i,
  output logic                        done_o,
  output logic [xdr_pkg::SideW-1:0]   rem_o
);
  import xdr_pkg::*;

  logic               busy_q;
  logic               done_q;
  logic [ModCntW-1:0] cnt_q;
  logic [63:0]        dvd_q;
  logic [SideW-1:0]   div_q;
  logic [SideW-1:0]   rem_q;
  logic [SideW-1:0]   rem_d;
  logic [63:0]        dvd_d;

  // Retire ModBits dividend bits by shift and conditional subtract
  always_comb begin
    logic [SideW:0]   t;
    logic [SideW-1:0] r;
    logic [63:0]      d;
    r = rem_q;
    d = dvd_q;
    for (int k = 0; k < ModBits; k++) begin
      t = {r, d[63]};
      d = d << 1;
      if (t >= {1'b0, div_q}) begin
        t = t - {1'b0, div_q};
      end
      r = t[SideW-1:0];
    end
    rem_d = r;
    dvd_d = d;
  end

  // Control: count ModIters iterations after start, then pulse done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ModCntW'(ModIters - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands on start, advance while busy
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
